>>> rtl/ael_pkg.sv
// Shared types, character codes and classification functions for the expression lexer.
package ael_pkg;

	typedef enum logic [3:0] {
		TOK_NUMBER   = 4'd0,
		TOK_LPAREN   = 4'd1,
		TOK_RPAREN   = 4'd2,
		TOK_EXPONENT = 4'd3,
		TOK_MULTIPLY = 4'd4,
		TOK_DIVIDE   = 4'd5,
		TOK_MODULUS  = 4'd6,
		TOK_PLUS     = 4'd7,
		TOK_MINUS    = 4'd8,
		TOK_UNKNOWN  = 4'd9,
		TOK_END      = 4'd10
	} token_type_t;

	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_INT  = 2'd1;
	localparam logic [1:0] PH_FRAC = 2'd2;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_POINT  = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef struct packed {
		logic       held_valid;
		logic [7:0] held_char;
		logic       held_start;
		logic [1:0] number_phase;
	} lex_state_t;

	typedef struct packed {
		token_type_t token_type;
		logic [7:0]  token_char;
		logic        token_start;
		logic        token_last;
		logic        stream_end;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic token_type_t class_of(input logic [7:0] c);
		token_type_t t;
		if (is_digit(c)) begin
			t = TOK_NUMBER;
		end else begin
			unique case (c)
				CH_LPAREN: t = TOK_LPAREN;
				CH_RPAREN: t = TOK_RPAREN;
				CH_CARET:  t = TOK_EXPONENT;
				CH_STAR:   t = TOK_MULTIPLY;
				CH_SLASH:  t = TOK_DIVIDE;
				CH_PCT:    t = TOK_MODULUS;
				CH_PLUS:   t = TOK_PLUS;
				CH_MINUS:  t = TOK_MINUS;
				default:   t = TOK_UNKNOWN;
			endcase
		end
		return t;
	endfunction

endpackage

>>> rtl/ael_step.sv
// Per-character labeling and next-state logic of the expression lexer.
module ael_step (
	input  ael_pkg::lex_state_t cur,
	input  logic [7:0]          char_code,
	input  logic                expr_end,
	output ael_pkg::lex_state_t nxt,
	output ael_pkg::token_t     tok,
	output logic                emit
);

	logic       cont;
	logic [1:0] cont_phase;
	logic       in_number;
	logic       c_digit;

	assign c_digit   = ael_pkg::is_digit(char_code);
	assign in_number = (cur.number_phase != ael_pkg::PH_NONE);

	always_comb begin
		cont       = 1'b0;
		cont_phase = ael_pkg::PH_NONE;
		if (cur.held_valid) begin
			if (cur.number_phase == ael_pkg::PH_INT) begin
				if (c_digit) begin
					cont       = 1'b1;
					cont_phase = ael_pkg::PH_INT;
				end else if (char_code == ael_pkg::CH_POINT) begin
					cont       = 1'b1;
					cont_phase = ael_pkg::PH_FRAC;
				end
			end else if (cur.number_phase[1]) begin
				if (c_digit) begin
					cont       = 1'b1;
					cont_phase = ael_pkg::PH_FRAC;
				end
			end else if ((cur.held_char == ael_pkg::CH_MINUS) && c_digit) begin
				cont       = 1'b1;
				cont_phase = ael_pkg::PH_INT;
			end
		end
	end

	always_comb begin
		tok.token_char  = cur.held_char;
		tok.token_start = cur.held_start;
		tok.token_last  = 1'b1;
		tok.stream_end  = 1'b1;
		tok.token_type  = in_number ? ael_pkg::TOK_NUMBER : ael_pkg::class_of(cur.held_char);
		nxt             = '0;
		emit            = 1'b1;
		if (expr_end) begin
			if (!cur.held_valid) begin
				tok.token_type  = ael_pkg::TOK_END;
				tok.token_char  = ael_pkg::CH_NUL;
				tok.token_start = 1'b1;
			end
		end else begin
			emit           = cur.held_valid;
			tok.stream_end = 1'b0;
			tok.token_last = !cont;
			if (cont) begin
				tok.token_type = ael_pkg::TOK_NUMBER;
			end
			if (!ael_pkg::is_space(char_code)) begin
				nxt.held_valid   = 1'b1;
				nxt.held_char    = char_code;
				nxt.held_start   = !cont;
				nxt.number_phase = cont ? cont_phase :
				                   (c_digit ? ael_pkg::PH_INT : ael_pkg::PH_NONE);
			end
		end
	end

endmodule

>>> rtl/ael_out_reg.sv
// One-entry result register between the lexer logic and the output channel.
module ael_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  ael_pkg::token_t load_tok,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output ael_pkg::token_t out_tok
);

	logic            valid_q;
	ael_pkg::token_t tok_q;

	assign room      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_tok   = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q <= load_tok;
		end
	end

endmodule

>>> rtl/arithmetic_expression_lexer.sv
// Top level of the streaming arithmetic expression lexer.
//
// Input channel (in_valid/in_ready): one request per character byte, or an
// end marker (expr_end=1, char_code ignored). Output channel
// (out_valid/out_ready): one labeled character per non-space character, carrying its
// token class, the character, start/last flags and stream_end.
// Each character's label is emitted when the next request arrives, since
// token boundaries and signed numbers depend on the following character.
// Whitespace gives no result. An end marker flushes the held character, or
// yields an end token if nothing is held, and clears the lexer state.
// A result is in the output register in the cycle after the request that
// completes it. One request per cycle is accepted while the output register
// has room; the single held-character register updates on each accepted one.
// The one-entry output register takes a new result in the same cycle its
// current result is taken; while the receiver stalls with a result waiting,
// in_ready is low and the lexer state holds.
// Reset clears the held character state and the output register's valid flag.
module arithmetic_expression_lexer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       expr_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] token_type,
	output logic [7:0] token_char,
	output logic       token_start,
	output logic       token_last,
	output logic       stream_end
);

	ael_pkg::lex_state_t state_q;
	ael_pkg::lex_state_t state_nxt;
	ael_pkg::token_t     step_tok;
	ael_pkg::token_t     out_tok;
	logic                emit;
	logic                accept;
	logic                room;

	assign in_ready = room;
	assign accept   = in_valid && room;

	ael_step u_step (
		.cur       (state_q),
		.char_code (char_code),
		.expr_end  (expr_end),
		.nxt       (state_nxt),
		.tok       (step_tok),
		.emit      (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	ael_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && emit),
		.load_tok  (step_tok),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_tok   (out_tok)
	);

	assign token_type  = 4'(out_tok.token_type);
	assign token_char  = out_tok.token_char;
	assign token_start = out_tok.token_start;
	assign token_last  = out_tok.token_last;
	assign stream_end  = out_tok.stream_end;

endmodule
